@@ rtl/pgc_pkg.sv @@
// ----------------------------------------------------------------------------
// pgc_pkg: shared types and constants of the palette gradient color block
// Beat payloads, register indexes, fixed-point constants for the phase
// reduction and segment split, and the per-channel linear blend.
// ----------------------------------------------------------------------------
`default_nettype none

package pgc_pkg;

  // Palette geometry and phase format.
  localparam int MAX_COLORS      = 8;
  localparam int PHASE_FRAC_BITS = 6;

  // Field widths of the beats and registers.
  localparam int PH_W    = 16;
  localparam int SLOT_W  = 3;
  localparam int RGB_W   = 24;
  localparam int CH_W    = 8;
  localparam int COUNT_W = 4;
  localparam int CFG_W   = COUNT_W;

  // Full circle in phase units and derived widths.
  localparam int CIRCLE = 360 << PHASE_FRAC_BITS;
  localparam int C_W    = $clog2(CIRCLE);
  localparam int IDX_W  = $clog2(MAX_COLORS);
  localparam int N_W    = $clog2(MAX_COLORS + 1);
  localparam int T_W    = $clog2(CIRCLE * MAX_COLORS);
  localparam int Q_RAW  = $clog2((2 ** PH_W - 1) / CIRCLE + 1);
  localparam int Q_W    = (Q_RAW < 1) ? 1 : Q_RAW;

  // Exact reciprocal for phase / CIRCLE with phase below 2^PH_W.
  localparam int             SP   = PH_W + C_W;
  localparam longint         RP   = ((longint'(1) << SP) + CIRCLE - 1) / CIRCLE;
  localparam int             RP_W = $clog2(RP + 1);
  localparam logic [RP_W-1:0] RP_V = RP_W'(RP);

  // Exact reciprocal for t / CIRCLE with t below 2^T_W.
  localparam int             ST   = T_W + C_W;
  localparam longint         RT   = ((longint'(1) << ST) + CIRCLE - 1) / CIRCLE;
  localparam int             RT_W = $clog2(RT + 1);
  localparam logic [RT_W-1:0] RT_V = RT_W'(RT);

  // Exact reciprocal for (rem * 256) / CIRCLE with rem below CIRCLE.
  localparam int             SF   = C_W + CH_W + C_W;
  localparam longint         RF   = ((longint'(1) << SF) + CIRCLE - 1) / CIRCLE;
  localparam int             RF_W = $clog2(RF + 1);
  localparam logic [RF_W-1:0] RF_V = RF_W'(RF);

  // Register indexes of the configuration port.
  typedef enum logic {
    CFG_COLOR_COUNT = 1'b0,
    CFG_SMOOTH      = 1'b1
  } pgc_cfg_e;

  // Item modes.
  typedef enum logic {
    MODE_COMPUTE = 1'b0,
    MODE_LOAD    = 1'b1
  } pgc_mode_e;

  // Input beat payload.
  typedef struct packed {
    logic              mode;
    logic [PH_W-1:0]   phase;
    logic [SLOT_W-1:0] entry_index;
    logic [RGB_W-1:0]  entry_color;
  } pgc_in_t;

  // Output beat payload.
  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } pgc_out_t;

  // Linear blend of one channel toward the next entry, truncated.
  function automatic logic [CH_W-1:0] blend_ch(input logic [CH_W-1:0] cur,
                                               input logic [CH_W-1:0] nxt,
                                               input logic [CH_W-1:0] frac);
    logic signed [CH_W:0]     diff;
    logic signed [CH_W:0]     fs;
    logic signed [2*CH_W+1:0] acc;
    diff = $signed({1'b0, nxt}) - $signed({1'b0, cur});
    fs   = $signed({1'b0, frac});
    acc  = $signed({2'b00, cur, {CH_W{1'b0}}}) + diff * fs;
    return acc[2*CH_W-1:CH_W];
  endfunction

endpackage

`default_nettype wire

@@ rtl/pgc_in_if.sv @@
// ----------------------------------------------------------------------------
// pgc_in_if: input channel of the palette gradient color block
// Valid/ready channel carrying one compute or palette load beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface pgc_in_if;
  logic             valid;
  logic             ready;
  pgc_pkg::pgc_in_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/pgc_out_if.sv @@
// ----------------------------------------------------------------------------
// pgc_out_if: output channel of the palette gradient color block
// Valid/ready channel carrying one RGB result beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface pgc_out_if;
  logic              valid;
  logic              ready;
  pgc_pkg::pgc_out_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/pgc_ram.sv @@
// ----------------------------------------------------------------------------
// pgc_ram: generic RAM with one write port and two registered read ports
// Read data updates only when the read enable is high and holds otherwise.
// ----------------------------------------------------------------------------
`default_nettype none

module pgc_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 8
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic      [WIDTH-1:0]         rdata_a_o,
  output logic      [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Two registered read ports.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_a_o <= mem_q[raddr_a_i];
      rdata_b_o <= mem_q[raddr_b_i];
    end
  end

endmodule

`default_nettype wire

@@ rtl/palette_gradient_color_top.sv @@
// Path: a compute beat is registered in stages s1 to s7 and then in the
// output register, where its color shows; load beats give no output beat.
// Throughput: one beat per cycle, compute and load mixed freely; the only
// stall is back pressure on the output register.
// The palette lives in an 8-entry RAM with two read ports, read and written
// in the same pipeline stage. Reset clears the configuration registers and pipeline valids.
// ----------------------------------------------------------------------------
// palette_gradient_color_top: cyclic color ramp over an RGB palette
// Reduces the phase modulo a full circle, splits the circle into segments,
// reads the segment entry and its successor, and blends them linearly.
// ----------------------------------------------------------------------------
`default_nettype none

module palette_gradient_color_top (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire pgc_pkg::pgc_cfg_e            cfg_idx_i,
  input  wire logic [pgc_pkg::CFG_W-1:0]    cfg_wdata_i,
  pgc_in_if.sink                            in_i,
  pgc_out_if.source                         out_o
);

  import pgc_pkg::*;

  // Configuration registers.
  logic [COUNT_W-1:0] count_q;
  logic               smooth_q;
  logic [N_W-1:0]     n_use;

  // Pipeline control.
  logic advance;
  logic s1_valid_q, s2_valid_q, s3_valid_q, s4_valid_q, s5_valid_q;
  logic s6_valid_q, s7_valid_q, out_valid_q;
  logic s1_load_q, s2_load_q, s3_load_q, s4_load_q, s5_load_q;

  // Load fields carried to the RAM stage.
  logic [SLOT_W-1:0] s1_slot_q, s2_slot_q, s3_slot_q, s4_slot_q, s5_slot_q;
  logic [RGB_W-1:0]  s1_rgb_q, s2_rgb_q, s3_rgb_q, s4_rgb_q, s5_rgb_q;

  // Datapath.
  logic [PH_W-1:0]      s1_phase_q, s2_phase_q;
  logic [PH_W+RP_W-1:0] q_prod;
  logic [Q_W-1:0]       q_d, s2_q_q;
  logic [PH_W-1:0]      qc;
  logic [C_W-1:0]       p_d, s3_p_q;
  logic [T_W-1:0]       t_d, s4_t_q, s5_t_q;
  logic [T_W+RT_W-1:0]  seg_prod;
  logic [IDX_W-1:0]     seg_d, s5_seg_q;
  logic [C_W-1:0]       rem_d, s6_rem_q;
  logic [IDX_W:0]       seg_inc;
  logic [IDX_W-1:0]     nx;
  logic                 ram_we;
  logic [RGB_W-1:0]     cur_rd, nxt_rd;
  logic [C_W+CH_W+RF_W-1:0] f_prod;
  logic [CH_W-1:0]      f_d, s7_f_q;
  logic [RGB_W-1:0]     s7_cur_q, s7_nxt_q;
  pgc_out_t             blend_d, out_q;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      smooth_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_COLOR_COUNT: count_q  <= cfg_wdata_i[COUNT_W-1:0];
        CFG_SMOOTH:      smooth_q <= cfg_wdata_i[0];
      endcase
    end
  end

  // Colors in use, limited to the palette size.
  assign n_use = (int'(count_q) > MAX_COLORS) ? N_W'(MAX_COLORS) : N_W'(count_q);

  // The whole pipeline moves unless the output register is held.
  assign advance  = !out_valid_q || out_o.ready;
  assign in_i.ready = advance;

  // Valid bits of each stage and mode bits up to the RAM stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      s4_valid_q  <= 1'b0;
      s5_valid_q  <= 1'b0;
      s6_valid_q  <= 1'b0;
      s7_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      s1_load_q   <= 1'b0;
      s2_load_q   <= 1'b0;
      s3_load_q   <= 1'b0;
      s4_load_q   <= 1'b0;
      s5_load_q   <= 1'b0;
    end else if (advance) begin
      s1_valid_q  <= in_i.valid;
      s2_valid_q  <= s1_valid_q;
      s3_valid_q  <= s2_valid_q;
      s4_valid_q  <= s3_valid_q;
      s5_valid_q  <= s4_valid_q;
      s6_valid_q  <= s5_valid_q && !s5_load_q;
      s7_valid_q  <= s6_valid_q;
      out_valid_q <= s7_valid_q;
      s1_load_q   <= (in_i.data.mode == MODE_LOAD);
      s2_load_q   <= s1_load_q;
      s3_load_q   <= s2_load_q;
      s4_load_q   <= s3_load_q;
      s5_load_q   <= s4_load_q;
    end
  end

  // Quotient of the phase by a full circle.
  assign q_prod = (PH_W+RP_W)'(s1_phase_q) * (PH_W+RP_W)'(RP_V);
  assign q_d    = Q_W'(q_prod >> SP);

  // Phase reduced into one circle.
  assign qc  = PH_W'(s2_q_q) * PH_W'(CIRCLE);
  assign p_d = C_W'(s2_phase_q - qc);

  // Phase scaled by the color count.
  assign t_d = T_W'(s3_p_q) * T_W'(n_use);

  // Segment number.
  assign seg_prod = (T_W+RT_W)'(s4_t_q) * (T_W+RT_W)'(RT_V);
  assign seg_d    = IDX_W'(seg_prod >> ST);

  // Position inside the segment and the following entry, wrapping.
  assign rem_d   = C_W'(s5_t_q - T_W'(s5_seg_q) * T_W'(CIRCLE));
  assign seg_inc = {1'b0, s5_seg_q} + (IDX_W+1)'(1);
  assign nx      = (int'(seg_inc) >= int'(n_use)) ? '0 : IDX_W'(seg_inc);

  // Load beats write the palette here; slots past the palette are dropped.
  assign ram_we = advance && s5_valid_q && s5_load_q && (int'(s5_slot_q) < MAX_COLORS);

  // Payload registers of the stages.
  always_ff @(posedge clk_i) begin
    if (advance) begin
      s1_phase_q <= in_i.data.phase;
      s1_slot_q  <= in_i.data.entry_index;
      s1_rgb_q   <= in_i.data.entry_color;
      s2_phase_q <= s1_phase_q;
      s2_q_q     <= q_d;
      s2_slot_q  <= s1_slot_q;
      s2_rgb_q   <= s1_rgb_q;
      s3_p_q     <= p_d;
      s3_slot_q  <= s2_slot_q;
      s3_rgb_q   <= s2_rgb_q;
      s4_t_q     <= t_d;
      s4_slot_q  <= s3_slot_q;
      s4_rgb_q   <= s3_rgb_q;
      s5_t_q     <= s4_t_q;
      s5_seg_q   <= seg_d;
      s5_slot_q  <= s4_slot_q;
      s5_rgb_q   <= s4_rgb_q;
      s6_rem_q   <= rem_d;
      s7_f_q     <= f_d;
      s7_cur_q   <= cur_rd;
      s7_nxt_q   <= nxt_rd;
      out_q      <= blend_d;
    end
  end

  // Palette storage.
  pgc_ram #(
    .WIDTH (RGB_W),
    .DEPTH (MAX_COLORS)
  ) u_palette (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .waddr_i   (IDX_W'(s5_slot_q)),
    .wdata_i   (s5_rgb_q),
    .re_i      (advance),
    .raddr_a_i (s5_seg_q),
    .raddr_b_i (nx),
    .rdata_a_o (cur_rd),
    .rdata_b_o (nxt_rd)
  );

  // Eight-bit blend fraction; zero in segment mode.
  assign f_prod = (C_W+CH_W+RF_W)'({s6_rem_q, {CH_W{1'b0}}}) * (C_W+CH_W+RF_W)'(RF_V);
  assign f_d    = smooth_q ? CH_W'(f_prod >> SF) : '0;

  // Channel blend, or white with an empty palette.
  always_comb begin
    if (n_use == '0) begin
      blend_d.red   = '1;
      blend_d.green = '1;
      blend_d.blue  = '1;
    end else begin
      blend_d.red   = blend_ch(s7_cur_q[23:16], s7_nxt_q[23:16], s7_f_q);
      blend_d.green = blend_ch(s7_cur_q[15:8], s7_nxt_q[15:8], s7_f_q);
      blend_d.blue  = blend_ch(s7_cur_q[7:0], s7_nxt_q[7:0], s7_f_q);
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  // Reduced phase stays inside one circle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s3_valid_q && !s3_load_q |-> int'(s3_p_q) < CIRCLE)
    else $error("reduced phase out of range");

  // Segment split leaves a remainder inside one segment.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s5_valid_q && !s5_load_q |-> int'(rem_d) < CIRCLE)
    else $error("segment remainder out of range");

  // Segment and its successor address entries in use.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s5_valid_q && !s5_load_q && (n_use != '0) |->
      (int'(s5_seg_q) < int'(n_use)) && (int'(nx) < int'(n_use)))
    else $error("palette read beyond colors in use");

  // A load beat never reaches the result stages.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && s5_valid_q && s5_load_q |=> !s6_valid_q)
    else $error("load beat produced a result");

endmodule

`default_nettype wire
